FILE: rtl/ebc_pkg.sv
// ebc_pkg: shared types, constants and helpers for the ghost-state boundary block
// payload structs, register indexes, opcodes and the 32-bit saturation helper
// no dependencies
package ebc_pkg;

   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // latency of the face path and of the inlet path, in register stages
   localparam int SLIP_LAT  = 5;
   localparam int INL_LAT   = 33;
   localparam int DIV_STEPS = 31;

   localparam logic [30:0] ONE_Q16  = 31'd65536;
   localparam logic [30:0] POS_MAX  = 31'h7FFF_FFFF;

   // register reset values
   localparam logic [1:0]  RST_DIMENSIONS = 2'd3;
   localparam logic [30:0] RST_DENSITY    = 31'd65536;
   localparam logic [30:0] RST_PRESSURE   = 31'd65536;
   localparam logic [30:0] RST_GAMMA      = 31'd91750;
   localparam logic [1:0]  DIMS_2D        = 2'd2;

   typedef enum logic [1:0] {
      OP_COPY  = 2'd0,
      OP_SLIP  = 2'd1,
      OP_INLET = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIMENSIONS = 3'd0,
      CSR_DENSITY    = 3'd1,
      CSR_VEL_X      = 3'd2,
      CSR_VEL_Y      = 3'd3,
      CSR_VEL_Z      = 3'd4,
      CSR_PRESSURE   = 3'd5,
      CSR_GAMMA      = 3'd6
   } csr_idx_type;

   typedef struct packed {
      op_type             opcode;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic signed [31:0] interior_density;
      logic signed [31:0] interior_mom_x;
      logic signed [31:0] interior_mom_y;
      logic signed [31:0] interior_mom_z;
      logic signed [31:0] interior_energy;
   } req_type;

   typedef struct packed {
      logic signed [31:0] ghost_density;
      logic signed [31:0] ghost_mom_x;
      logic signed [31:0] ghost_mom_y;
      logic signed [31:0] ghost_mom_z;
      logic signed [31:0] ghost_energy;
   } rsp_type;

   typedef struct packed {
      logic               dims_2d;
      logic [30:0]        density;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [30:0]        pressure;
      logic [30:0]        gamma;
   } cfg_type;

   typedef struct packed {
      op_type  opcode;
      rsp_type rsp;
   } slip_out_type;

   // clamp a wide two's complement value to 32 bits signed
   function automatic logic [31:0] sat32(input logic [65:0] x);
      logic [31:0] r;
      if (x[65:31] == {35{x[65]}}) begin
         r = x[31:0];
      end else if (x[65]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

FILE: rtl/euler_ghost_state_bc.sv
// euler_ghost_state_bc: ghost-cell state for one boundary face per cycle
// uses ebc_pkg, ebc_slip and ebc_inlet
//
// usage
//   a face is transferred on an edge with start high and busy low; busy is
//   high only during reset, so one face can enter every cycle
//   each face gives one result on rsp_data, marked by rsp_valid for one
//   cycle; throughput is one face per cycle, and the output is timed by
//   the 31-stage restoring divider of the inlet pressure term plus capture
//   and output
//   the face path (copy or slip mirror) takes 5 stages and is delayed to
//   line up with the inlet path
//   registers take csr_we, csr_index, csr_wdata; the user writes them only while no
//   result is outstanding (not enforced); the inlet state follows them without a sweep
//   reset is synchronous and clears the valid bits and the registers to
//   2D off (3D), density 1.0, velocity 0, pressure 1.0, gamma 1.4
//   the receiver cannot stall: a result is presented exactly once
module euler_ghost_state_bc (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ebc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output ebc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [ebc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ebc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ebc_pkg::*;

   localparam int SLIP_DLY = INL_LAT - SLIP_LAT;

   logic         dims_2d;
   logic [1:0]   dims_raw_ff;
   logic [30:0]  density_ff, pressure_ff, gamma_ff;
   logic [31:0]  vel_x_ff, vel_y_ff, vel_z_ff;
   cfg_type      cfg;
   logic         accept;
   logic         slip_valid;
   slip_out_type slip_data;
   rsp_type      inl_data;
   logic         dly_valid_ff [SLIP_DLY];
   slip_out_type dly_data_ff [SLIP_DLY];
   logic         rsp_valid_ff;
   rsp_type      rsp_in, rsp_ff;
   op_type       rsp_op_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_raw_ff <= RST_DIMENSIONS;
         density_ff  <= RST_DENSITY;
         vel_x_ff    <= '0;
         vel_y_ff    <= '0;
         vel_z_ff    <= '0;
         pressure_ff <= RST_PRESSURE;
         gamma_ff    <= RST_GAMMA;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_DIMENSIONS: dims_raw_ff <= csr_wdata[1:0];
            CSR_DENSITY:    density_ff  <= csr_wdata[30:0];
            CSR_VEL_X:      vel_x_ff    <= csr_wdata;
            CSR_VEL_Y:      vel_y_ff    <= csr_wdata;
            CSR_VEL_Z:      vel_z_ff    <= csr_wdata;
            CSR_PRESSURE:   pressure_ff <= csr_wdata[30:0];
            CSR_GAMMA:      gamma_ff    <= csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   assign dims_2d = (dims_raw_ff == DIMS_2D);

   always_comb begin
      cfg.dims_2d  = dims_2d;
      cfg.density  = density_ff;
      cfg.vel_x    = vel_x_ff;
      cfg.vel_y    = vel_y_ff;
      cfg.vel_z    = vel_z_ff;
      cfg.pressure = pressure_ff;
      cfg.gamma    = gamma_ff;
   end

   ebc_slip u_slip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .req       (req_data),
      .dims_2d   (dims_2d),
      .out_valid (slip_valid),
      .out_data  (slip_data)
   );

   ebc_inlet u_inlet (
      .clock (clock),
      .cfg   (cfg),
      .inl   (inl_data)
   );

   // align the face path with the inlet path
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLIP_DLY; k++) begin
            dly_valid_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         dly_valid_ff[0] <= slip_valid;
         for (int k = 1; k < SLIP_DLY; k++) begin
            dly_valid_ff[k] <= dly_valid_ff[k-1];
         end
         rsp_valid_ff <= dly_valid_ff[SLIP_DLY-1];
      end
   end

   always_ff @(posedge clock) begin
      dly_data_ff[0] <= slip_data;
      for (int k = 1; k < SLIP_DLY; k++) begin
         dly_data_ff[k] <= dly_data_ff[k-1];
      end
      rsp_ff    <= rsp_in;
      rsp_op_ff <= dly_data_ff[SLIP_DLY-1].opcode;
   end

   // result select
   always_comb begin
      if (dly_data_ff[SLIP_DLY-1].opcode == OP_INLET) begin
         rsp_in = inl_data;
      end else begin
         rsp_in = dly_data_ff[SLIP_DLY-1].rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // every result traces back to a face transfer a fixed time earlier
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, INL_LAT + 1))
      else $error("result without a matching face transfer");

   // inlet results carry nonnegative density and energy
   a_inlet_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_op_ff == OP_INLET) |->
         (!rsp_data.ghost_energy[31] && !rsp_data.ghost_density[31]))
      else $error("inlet result with negative density or energy");

   // nothing comes out right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

FILE: rtl/ebc_slip.sv
// ebc_slip: five-stage face path, copy or slip-wall momentum mirror
// depends on ebc_pkg
module ebc_slip (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  ebc_pkg::req_type     req,
   input  logic                 dims_2d,
   output logic                 out_valid,
   output ebc_pkg::slip_out_type out_data
);
   import ebc_pkg::*;

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   op_type              op1_ff, op2_ff, op3_ff, op4_ff;
   logic signed [31:0]  rho1_ff, rho2_ff, rho3_ff, rho4_ff;
   logic signed [31:0]  e1_ff, e2_ff, e3_ff, e4_ff;
   logic signed [31:0]  n1_in [3];
   logic signed [31:0]  m1_in [3];
   logic signed [31:0]  n1_ff [3];
   logic signed [31:0]  m1_ff [3];
   logic signed [31:0]  n2_ff [3];
   logic signed [31:0]  m2_ff [3];
   logic signed [31:0]  n3_ff [3];
   logic signed [31:0]  m3_ff [3];
   logic signed [31:0]  m4_ff [3];
   logic signed [63:0]  p2_in [3];
   logic signed [63:0]  p2_ff [3];
   logic [65:0]         sum3;
   logic signed [31:0]  dot3_in, dot3_ff;
   logic signed [63:0]  q4_in [3];
   logic signed [63:0]  q4_ff [3];
   logic [31:0]         g5_in [3];
   slip_out_type        out_in, out_ff;

   // stage 1 input capture, z parts dropped in 2D
   always_comb begin
      n1_in[0] = req.normal_x;
      n1_in[1] = req.normal_y;
      n1_in[2] = dims_2d ? '0 : req.normal_z;
      m1_in[0] = req.interior_mom_x;
      m1_in[1] = req.interior_mom_y;
      m1_in[2] = dims_2d ? '0 : req.interior_mom_z;
   end

   // stage 2 products n*m
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         p2_in[d] = n1_ff[d] * m1_ff[d];
      end
   end

   // stage 3 dot product, exact floor then clamp
   always_comb begin
      sum3 = {{2{p2_ff[0][63]}}, p2_ff[0]} + {{2{p2_ff[1][63]}}, p2_ff[1]}
           + {{2{p2_ff[2][63]}}, p2_ff[2]};
      dot3_in = sat32({{16{sum3[65]}}, sum3[65:16]});
   end

   // stage 4 dot*n
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         q4_in[d] = dot3_ff * n3_ff[d];
      end
   end

   // stage 5 mirror m - 2(n.m)n and copy select
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         g5_in[d] = sat32({{34{m4_ff[d][31]}}, m4_ff[d]}
                          - {{17{q4_ff[d][63]}}, q4_ff[d][63:15]});
      end
      out_in.opcode            = op4_ff;
      out_in.rsp.ghost_density = rho4_ff;
      out_in.rsp.ghost_energy  = e4_ff;
      if (op4_ff == OP_SLIP) begin
         out_in.rsp.ghost_mom_x = g5_in[0];
         out_in.rsp.ghost_mom_y = g5_in[1];
         out_in.rsp.ghost_mom_z = g5_in[2];
      end else begin
         out_in.rsp.ghost_mom_x = m4_ff[0];
         out_in.rsp.ghost_mom_y = m4_ff[1];
         out_in.rsp.ghost_mom_z = m4_ff[2];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      op1_ff  <= req.opcode;
      rho1_ff <= req.interior_density;
      e1_ff   <= req.interior_energy;
      op2_ff  <= op1_ff;
      rho2_ff <= rho1_ff;
      e2_ff   <= e1_ff;
      op3_ff  <= op2_ff;
      rho3_ff <= rho2_ff;
      e3_ff   <= e2_ff;
      dot3_ff <= dot3_in;
      op4_ff  <= op3_ff;
      rho4_ff <= rho3_ff;
      e4_ff   <= e3_ff;
      out_ff  <= out_in;
      for (int d = 0; d < 3; d++) begin
         n1_ff[d] <= n1_in[d];
         m1_ff[d] <= m1_in[d];
         n2_ff[d] <= n1_ff[d];
         m2_ff[d] <= m1_ff[d];
         p2_ff[d] <= p2_in[d];
         n3_ff[d] <= n2_ff[d];
         m3_ff[d] <= m2_ff[d];
         m4_ff[d] <= m3_ff[d];
         q4_ff[d] <= q4_in[d];
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = out_ff;

endmodule

FILE: rtl/ebc_inlet.sv
// ebc_inlet: free-running pipeline for the inlet free-stream state
// restoring divider for p/(gamma-1), one quotient bit a stage; depends on ebc_pkg
module ebc_inlet (
   input  logic              clock,
   input  ebc_pkg::cfg_type  cfg,
   output ebc_pkg::rsp_type  inl
);
   import ebc_pkg::*;

   localparam int KE_DLY = INL_LAT - 6;

   logic signed [31:0] vel_in [3];
   logic signed [31:0] vel1_ff [3];
   logic [31:0]        abs1_ff [3];
   logic [63:0]        sq2_ff [3];
   logic signed [63:0] rm2_ff [3];
   logic [63:0]        vsq3_ff;
   logic [2:0][31:0]   gm3_ff, gm4_ff, gm5_ff;
   logic [62:0]        hi4_ff, lo4_ff;
   logic [63:0]        ke_sum;
   logic [30:0]        ke5_in, ke5_ff;
   logic [30:0]        ke_dly_ff [KE_DLY];
   logic [2:0][31:0]   gm_dly_ff [KE_DLY];
   logic [30:0]        den;
   logic               gamma_low;
   logic [30:0]        div_r_in [DIV_STEPS+1];
   logic [30:0]        div_q_in [DIV_STEPS+1];
   logic [30:0]        div_low_in [DIV_STEPS+1];
   logic               div_sat_in [DIV_STEPS+1];
   logic [30:0]        div_r_ff [DIV_STEPS+1];
   logic [30:0]        div_q_ff [DIV_STEPS+1];
   logic [30:0]        div_low_ff [DIV_STEPS+1];
   logic               div_sat_ff [DIV_STEPS+1];
   logic [31:0]        r_sh;
   logic [30:0]        pt;
   logic [31:0]        e_sum;
   rsp_type            inl_in, inl_ff;

   // velocity with z dropped in 2D
   always_comb begin
      vel_in[0] = cfg.vel_x;
      vel_in[1] = cfg.vel_y;
      vel_in[2] = cfg.dims_2d ? '0 : cfg.vel_z;
   end

   // kinetic energy term, matches the split hi/lo product
   always_comb begin
      ke_sum = {1'b0, hi4_ff} + {33'd0, lo4_ff[62:32]};
      ke5_in = (|ke_sum[63:48]) ? POS_MAX : ke_sum[47:17];
   end

   // divider: precheck for quotient overflow, then one bit a stage
   always_comb begin
      den       = cfg.gamma - ONE_Q16;
      gamma_low = (cfg.gamma <= ONE_Q16);
      div_r_in[0]   = {15'd0, cfg.pressure[30:15]};
      div_q_in[0]   = '0;
      div_low_in[0] = {cfg.pressure[14:0], 16'd0};
      div_sat_in[0] = gamma_low || ({15'd0, cfg.pressure[30:15]} >= den);
      r_sh = '0;
      for (int j = 1; j <= DIV_STEPS; j++) begin
         r_sh = {div_r_ff[j-1], div_low_ff[j-1][30]};
         if (r_sh >= {1'b0, den}) begin
            div_r_in[j] = 31'(r_sh - {1'b0, den});
            div_q_in[j] = {div_q_ff[j-1][29:0], 1'b1};
         end else begin
            div_r_in[j] = r_sh[30:0];
            div_q_in[j] = {div_q_ff[j-1][29:0], 1'b0};
         end
         div_low_in[j] = {div_low_ff[j-1][29:0], 1'b0};
         div_sat_in[j] = div_sat_ff[j-1];
      end
   end

   // final energy sum and output assembly
   always_comb begin
      pt    = div_sat_ff[DIV_STEPS] ? POS_MAX : div_q_ff[DIV_STEPS];
      e_sum = {1'b0, pt} + {1'b0, ke_dly_ff[KE_DLY-1]};
      inl_in.ghost_density = {1'b0, cfg.density};
      inl_in.ghost_mom_x   = gm_dly_ff[KE_DLY-1][0];
      inl_in.ghost_mom_y   = gm_dly_ff[KE_DLY-1][1];
      inl_in.ghost_mom_z   = gm_dly_ff[KE_DLY-1][2];
      inl_in.ghost_energy  = e_sum[31] ? {1'b0, POS_MAX} : e_sum;
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < 3; d++) begin
         vel1_ff[d] <= vel_in[d];
         abs1_ff[d] <= vel_in[d][31] ? (~vel_in[d] + 32'd1) : vel_in[d];
         sq2_ff[d]  <= abs1_ff[d] * abs1_ff[d];
         rm2_ff[d]  <= $signed({1'b0, cfg.density}) * vel1_ff[d];
         gm3_ff[d]  <= sat32({{18{rm2_ff[d][63]}}, rm2_ff[d][63:16]});
      end
      vsq3_ff <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      hi4_ff  <= cfg.density * vsq3_ff[63:32];
      lo4_ff  <= cfg.density * vsq3_ff[31:0];
      gm4_ff  <= gm3_ff;
      gm5_ff  <= gm4_ff;
      ke5_ff  <= ke5_in;
      ke_dly_ff[0] <= ke5_ff;
      gm_dly_ff[0] <= gm5_ff;
      for (int k = 1; k < KE_DLY; k++) begin
         ke_dly_ff[k] <= ke_dly_ff[k-1];
         gm_dly_ff[k] <= gm_dly_ff[k-1];
      end
      for (int j = 0; j <= DIV_STEPS; j++) begin
         div_r_ff[j]   <= div_r_in[j];
         div_q_ff[j]   <= div_q_in[j];
         div_low_ff[j] <= div_low_in[j];
         div_sat_ff[j] <= div_sat_in[j];
      end
      inl_ff <= inl_in;
   end

   assign inl = inl_ff;

endmodule
